// ----- hw/rtl/cd_pkg.sv -----
// Shared types and constants for the circular deque.
package cd_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned OUT_W    = 40;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic signed [DATA_W-1:0] NO_DATA = -32'sd1;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ_FRONT = 3'd4,
    OP_READ_BACK  = 3'd5
  } op_t;

  // Moves that the top level orders along the row of cells.
  typedef struct packed {
    logic shift_up;    // every cell takes its lower neighbor, cell 0 takes the pushed word
    logic shift_down;  // every cell takes its upper neighbor
    logic push_back;   // the cell just past the back takes the pushed word
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/circular_deque.sv -----
// A command beat yields its registered result beat on out_* in the cycle after acceptance.
// Throughput: one command per cycle; the output register stalls intake only while
// a result waits and out_tready is low. Front pushes and front pops shift the whole cell row at once.
// Reset (rst_n low, synchronous): count goes to zero, capacity to 16, output empties.
// Cell contents are not reset; entries beyond the count are never shown.
module circular_deque #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cd_pkg::DATA_W-1:0]        in_tdata,   // [31:0] push_value
  input  logic [cd_pkg::FUNC_W-1:0]        in_tuser,   // [2:0] func
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cd_pkg::OUT_W-1:0]         out_tdata,  // [0] accepted, [32:1] read_data,
                                                       // [33] is_empty, [34] is_full, pad
  input  logic                             cfg_wr_en,
  input  logic [cd_pkg::CAP_W-1:0]         cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > cd_pkg::CAP_W) ? CNT_W : cd_pkg::CAP_W;

  logic [cd_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic [cd_pkg::OUT_W-1:0] out_data_r;
  logic [cd_pkg::OUT_W-1:0] out_data_nxt;

  logic                     in_fire;
  logic [CMP_W-1:0]         cap_eff;
  logic                     full;
  logic                     empty;
  logic                     ok;
  logic                     full_after;
  logic                     empty_after;
  logic signed [cd_pkg::DATA_W-1:0] rd_data;
  logic signed [cd_pkg::DATA_W-1:0] back_word;
  cd_pkg::cell_ctrl_t       ctrl;
  cd_pkg::op_t              op;

  logic signed [cd_pkg::DATA_W-1:0] cell_data [MAX_ENTRIES];
  logic signed [cd_pkg::DATA_W-1:0] cell_back [MAX_ENTRIES];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign op        = cd_pkg::op_t'(in_tuser);

  // Saturate the capacity register to the row length.
  always_comb begin
    if (CMP_W'(cap_r) > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CMP_W'(cap_r);
    end
  end

  assign full  = CMP_W'(count_r) >= cap_eff;
  assign empty = (count_r == '0);

  always_comb begin
    back_word = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      back_word = back_word | cell_back[i];
    end
  end

  always_comb begin
    ok        = 1'b0;
    count_nxt = count_r;
    ctrl      = '0;
    rd_data   = cd_pkg::NO_DATA;
    case (op)
      cd_pkg::OP_PUSH_FRONT: begin
        if (!full) begin
          ok            = 1'b1;
          count_nxt     = count_r + CNT_W'(1);
          ctrl.shift_up = 1'b1;
        end
      end
      cd_pkg::OP_PUSH_BACK: begin
        if (!full) begin
          ok             = 1'b1;
          count_nxt      = count_r + CNT_W'(1);
          ctrl.push_back = 1'b1;
        end
      end
      cd_pkg::OP_POP_FRONT: begin
        if (!empty) begin
          ok              = 1'b1;
          count_nxt       = count_r - CNT_W'(1);
          ctrl.shift_down = 1'b1;
        end
      end
      cd_pkg::OP_POP_BACK: begin
        if (!empty) begin
          ok        = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      cd_pkg::OP_READ_FRONT: begin
        if (!empty) begin
          ok      = 1'b1;
          rd_data = cell_data[0];
        end
      end
      cd_pkg::OP_READ_BACK: begin
        if (!empty) begin
          ok      = 1'b1;
          rd_data = back_word;
        end
      end
      default: begin
      end
    endcase
    // Hold the row unless a beat is taken.
    if (!in_fire) begin
      ctrl = '0;
    end
  end

  assign empty_after  = (count_nxt == '0);
  assign full_after   = CMP_W'(count_nxt) >= cap_eff;
  assign out_data_nxt = {5'd0, full_after, empty_after, rd_data, ok};

  generate
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic signed [cd_pkg::DATA_W-1:0] lower;
      logic signed [cd_pkg::DATA_W-1:0] upper;
      if (g == 0) begin : g_first
        assign lower = in_tdata;
      end else begin : g_mid_lo
        assign lower = cell_data[g-1];
      end
      if (g == MAX_ENTRIES - 1) begin : g_last
        assign upper = cell_data[g];
      end else begin : g_mid_hi
        assign upper = cell_data[g+1];
      end
      cd_cell #(
        .INDEX (g),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_r),
        .push_value (in_tdata),
        .lower_data (lower),
        .upper_data (upper),
        .data       (cell_data[g]),
        .back_data  (cell_back[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= cd_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/cd_cell.sv -----
// One storage cell of the deque row: holds one entry and trades it with its neighbors.
module cd_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic                               clk,
  input  cd_pkg::cell_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                   count,
  input  logic signed [cd_pkg::DATA_W-1:0]   push_value,
  input  logic signed [cd_pkg::DATA_W-1:0]   lower_data,
  input  logic signed [cd_pkg::DATA_W-1:0]   upper_data,
  output logic signed [cd_pkg::DATA_W-1:0]   data,
  output logic signed [cd_pkg::DATA_W-1:0]   back_data
);

  logic signed [cd_pkg::DATA_W-1:0] data_r;
  logic signed [cd_pkg::DATA_W-1:0] data_nxt;
  logic                             is_back;
  logic                             is_slot_after_back;

  assign is_back            = (count == CNT_W'(INDEX + 1));
  assign is_slot_after_back = (count == CNT_W'(INDEX));

  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_up) begin
      data_nxt = lower_data;
    end else if (ctrl.shift_down) begin
      data_nxt = upper_data;
    end else if (ctrl.push_back && is_slot_after_back) begin
      data_nxt = push_value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data      = data_r;
  // Drive zeros unless this cell holds the back entry, so the top can OR the row.
  assign back_data = is_back ? data_r : '0;

endmodule

// ----- hw/rtl/cd_checker.sv -----
// Port-level checks for the circular deque, bound to the top level.
module cd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [cd_pkg::OUT_W-1:0]    out_tdata
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Intake is open whenever the output register is empty.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("command refused with free output register");

  // A refused operation reports the all-ones word.
  a_refused_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == 32'hFFFF_FFFF)
    else $error("refused operation returned data");

  // Reset empties the output.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind circular_deque cd_checker u_cd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
